@@ hw/rtl/porq_pkg.sv @@
// ============================================================================
// porq_pkg: shared types and constants for the policy ordered ready queue
// Request and response payloads, opcodes, policies and controller commands.
// ============================================================================
package porq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int OCC_W           = 7;

  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_TAKE_FIRST = 2'd1,
    OP_TAKE_LAST  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    POL_FCFS = 2'd0,
    POL_RR   = 2'd1,
    POL_PRIO = 2'd2
  } policy_t;

  typedef enum logic [1:0] {
    RSP_OK    = 2'd0,
    RSP_EMPTY = 2'd1,
    RSP_FULL  = 2'd2
  } rsp_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_SHIFT_LOAD,
    S_SHIFT,
    S_FINISH
  } state_t;

  typedef struct packed {
    op_t         operation;
    logic [15:0] entry_id;
    logic [31:0] entry_tick;
    logic [7:0]  entry_prio;
  } req_t;

  typedef struct packed {
    rsp_status_t      status;
    logic [15:0]      taken_id;
    logic [31:0]      taken_tick;
    logic [7:0]       taken_prio;
    logic [OCC_W-1:0] occupancy;
  } rsp_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] tick;
    logic [7:0]  prio;
  } entry_t;

  typedef struct packed {
    logic        ins_wr;
    logic        scan_init;
    logic        scan_rd;
    logic        shift_load;
    logic        shift_rd;
    logic        count_dec;
    logic        rsp_en;
    logic        rsp_take;
    rsp_status_t rsp_status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic at_last;
  } stat_t;

endpackage

@@ hw/rtl/porq_ctrl.sv @@
// ============================================================================
// porq_ctrl: sequencer for the ready queue
// Decodes requests, steps the scan over held slots and the compaction pass.
// ============================================================================
module porq_ctrl
  import porq_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  op_t   op,
  input  stat_t stat,
  output logic  busy,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start && (op == OP_TAKE_FIRST || op == OP_TAKE_LAST) && !stat.empty) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.at_last) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END:   state_nxt = S_SHIFT_LOAD;
      S_SHIFT_LOAD: state_nxt = S_SHIFT;
      S_SHIFT: begin
        if (stat.at_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH:     state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (op)
            OP_INSERT: begin
              cmd.rsp_en = 1'b1;
              if (stat.full) begin
                cmd.rsp_status = RSP_FULL;
              end else begin
                cmd.ins_wr     = 1'b1;
                cmd.rsp_status = RSP_OK;
              end
            end
            OP_TAKE_FIRST, OP_TAKE_LAST: begin
              if (stat.empty) begin
                cmd.rsp_en     = 1'b1;
                cmd.rsp_status = RSP_EMPTY;
              end else begin
                cmd.scan_init = 1'b1;
              end
            end
            default: begin
              cmd.rsp_en     = 1'b1;
              cmd.rsp_status = RSP_OK;
            end
          endcase
        end
      end
      S_SCAN:       cmd.scan_rd = 1'b1;
      S_SCAN_END:   ;
      S_SHIFT_LOAD: cmd.shift_load = 1'b1;
      S_SHIFT:      cmd.shift_rd = !stat.at_last;
      S_FINISH: begin
        cmd.rsp_en     = 1'b1;
        cmd.rsp_take   = 1'b1;
        cmd.count_dec  = 1'b1;
        cmd.rsp_status = RSP_OK;
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/porq_dp.sv @@
// ============================================================================
// porq_dp: slot memory, scan comparator and response register
// One read and one write port on the slots; one comparator shared by scan.
// ============================================================================
module porq_dp
  import porq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
  input  logic    clk,
  input  logic    rst_n,
  input  req_t    in_data,
  input  policy_t policy,
  input  cmd_t    cmd,
  output stat_t   stat,
  output logic    out_valid,
  output rsp_t    out_data
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t mem [QUEUE_DEPTH];

  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] cmp_idx_r;
  logic          cmp_vld_r;
  logic [IW-1:0] wb_idx_r;
  logic          wb_vld_r;
  logic          last_mode_r;
  entry_t        rdata_r;
  entry_t        best_r;
  logic [IW-1:0] best_idx_r;
  logic          out_valid_r;
  rsp_t          out_data_r;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  logic          better;
  logic          pick;
  entry_t        ins_entry;

  assign ins_entry = '{id: in_data.entry_id, tick: in_data.entry_tick,
                       prio: in_data.entry_prio};

  assign stat.full    = (count_r >= CW'(QUEUE_DEPTH));
  assign stat.empty   = (count_r == '0);
  assign stat.at_last = (CW'(idx_r) == count_r - CW'(1));

  always_comb begin
    rd_en   = cmd.scan_rd || cmd.shift_rd;
    rd_addr = cmd.shift_rd ? idx_r + IW'(1) : idx_r;
    wr_en   = cmd.ins_wr || wb_vld_r;
    wr_addr = cmd.ins_wr ? count_r[IW-1:0] : wb_idx_r;
    wr_data = cmd.ins_wr ? ins_entry : rdata_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    if (policy == POL_PRIO) begin
      better = (rdata_r.prio != best_r.prio) ? (rdata_r.prio > best_r.prio)
                                              : (rdata_r.id < best_r.id);
    end else begin
      better = (rdata_r.tick != best_r.tick) ? (rdata_r.tick < best_r.tick)
                                              : (rdata_r.id < best_r.id);
    end
    pick = (cmp_idx_r == '0) || (last_mode_r ? !better : better);
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins_wr) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.count_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      wb_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      cmp_vld_r   <= cmd.scan_rd;
      wb_vld_r    <= cmd.shift_rd;
      out_valid_r <= cmd.rsp_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      idx_r       <= '0;
      last_mode_r <= (in_data.operation == OP_TAKE_LAST);
    end else if (cmd.shift_load) begin
      idx_r <= best_idx_r;
    end else if (cmd.scan_rd || cmd.shift_rd) begin
      idx_r <= idx_r + IW'(1);
    end
    cmp_idx_r <= idx_r;
    wb_idx_r  <= idx_r;
    if (cmp_vld_r && pick) begin
      best_r     <= rdata_r;
      best_idx_r <= cmp_idx_r;
    end
    if (cmd.rsp_en) begin
      out_data_r.status     <= cmd.rsp_status;
      out_data_r.taken_id   <= cmd.rsp_take ? best_r.id : '0;
      out_data_r.taken_tick <= cmd.rsp_take ? best_r.tick : '0;
      out_data_r.taken_prio <= cmd.rsp_take ? best_r.prio : '0;
      out_data_r.occupancy  <= OCC_W'(count_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/policy_ordered_ready_queue.sv @@
// ============================================================================
// policy_ordered_ready_queue: bounded double-ended ready queue
// Holds process entries in arrival order; takes return the best or worst one.
// ============================================================================
// Request channel: an operation is taken on a clock edge with start high and
// busy low. Insert stores the entry at the tail; take-first removes the best
// entry, take-last the worst, under the policy register (tick order, or
// priority order), ties broken by lower id.
// Response channel: out_valid pulses for one cycle with out_data; there is
// no backpressure, the receiver must take it in that cycle.
// Sequencing: insert, empty take, full insert and unknown opcodes respond in
// the cycle after acceptance and leave busy low. A take with N entries held
// scans all N slots through the single memory read port with one comparator,
// then compacts the slots after the removed one (K = N-1-pick moves, one a cycle).
// Configuration: APB register 0 (byte address 0) holds the policy; write it
// only while idle. pready is tied high.
// Reset: rst_n (synchronous) empties the queue and sets the policy to
// first-come order.
// ============================================================================
module policy_ordered_ready_queue
  import porq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  req_t        in_data,
  output logic        out_valid,
  output rsp_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  policy_t policy_r;
  cmd_t    cmd;
  stat_t   stat;
  logic    reg_sel;

  assign reg_sel = (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {30'd0, policy_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_FCFS;
    end else if (psel && penable && pwrite && reg_sel) begin
      policy_r <= policy_t'(pwdata[1:0]);
    end
  end

  porq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_data.operation),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  porq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .policy    (policy_r),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
